### sv/rbd2x_pkg.sv
// rbd2x_pkg: shared constants, types and helpers of the RGBA 2x2 box downsampler.
// No dependencies; used by the interfaces, the top level and the test bench.
package rbd2x_pkg;

    // Line store geometry
    localparam int MAX_WIDTH  = 4096;
    localparam int HEIGHT_CAP = 4096;
    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int LINE_AW    = $clog2(LINE_DEPTH);

    // Counter and dimension widths
    localparam int WCNT_W = $clog2(MAX_WIDTH);
    localparam int HCNT_W = $clog2(HEIGHT_CAP);
    localparam int WDIM_W = WCNT_W + 1;
    localparam int HDIM_W = HCNT_W + 1;

    // Channel layout
    localparam int CH_W   = 8;
    localparam int NCH    = 4;
    localparam int PSUM_W = CH_W + 1;
    localparam int QSUM_W = CH_W + 3;

    // Config port
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = CFG_IDX_W'(1);

    typedef logic [CH_W-1:0]             chan_t;
    typedef logic [NCH-1:0][CH_W-1:0]    pixel_t;
    typedef logic [NCH-1:0][PSUM_W-1:0]  pair_t;

    // Clamp a raw width register to 1..MAX_WIDTH
    function automatic logic [WDIM_W-1:0] eff_width(input logic [CFG_W-1:0] v);
        logic [31:0] t;
        t = 32'(v);
        if (t == 32'd0) begin
            t = 32'd1;
        end else if (t > 32'(MAX_WIDTH)) begin
            t = 32'(MAX_WIDTH);
        end
        return t[WDIM_W-1:0];
    endfunction

    // Clamp a raw height register to 1..HEIGHT_CAP
    function automatic logic [HDIM_W-1:0] eff_height(input logic [CFG_W-1:0] v);
        logic [31:0] t;
        t = 32'(v);
        if (t == 32'd0) begin
            t = 32'd1;
        end else if (t > 32'(HEIGHT_CAP)) begin
            t = 32'(HEIGHT_CAP);
        end
        return t[HDIM_W-1:0];
    endfunction

endpackage

### sv/rbd2x_pix_if.sv
// rbd2x_pix_if: source pixel channel (valid/ready plus RGBA8 payload).
// Depends on rbd2x_pkg.
interface rbd2x_pix_if;
    logic                  valid;
    logic                  ready;
    rbd2x_pkg::chan_t      in_red;
    rbd2x_pkg::chan_t      in_green;
    rbd2x_pkg::chan_t      in_blue;
    rbd2x_pkg::chan_t      in_alpha;

    modport source (output valid, output in_red, output in_green, output in_blue,
                    output in_alpha, input ready);
    modport sink   (input valid, input in_red, input in_green, input in_blue,
                    input in_alpha, output ready);
endinterface

### sv/rbd2x_out_if.sv
// rbd2x_out_if: downsampled pixel channel (valid/ready, RGBA8 and frame_last).
// Depends on rbd2x_pkg.
interface rbd2x_out_if;
    logic                  valid;
    logic                  ready;
    rbd2x_pkg::chan_t      out_red;
    rbd2x_pkg::chan_t      out_green;
    rbd2x_pkg::chan_t      out_blue;
    rbd2x_pkg::chan_t      out_alpha;
    logic                  frame_last;

    modport source (output valid, output out_red, output out_green, output out_blue,
                    output out_alpha, output frame_last, input ready);
    modport sink   (input valid, input out_red, input out_green, input out_blue,
                    input out_alpha, input frame_last, output ready);
endinterface

### sv/rbd2x_cfg_if.sv
// rbd2x_cfg_if: register write channel (valid/ready, register index, data).
// Depends on rbd2x_pkg.
interface rbd2x_cfg_if;
    logic                                  valid;
    logic                                  ready;
    logic [rbd2x_pkg::CFG_IDX_W-1:0]       index;
    logic [rbd2x_pkg::CFG_W-1:0]           data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### sv/rgba_box_downsample_2x.sv
// rgba_box_downsample_2x: streaming 2x2 box-filter downsampler for RGBA8 pixels.
// Depends on rbd2x_pkg, rbd2x_pix_if, rbd2x_out_if, rbd2x_cfg_if and rbd2x_ram.
//
// Source pixels arrive in raster order on pix_in, one item per clock at full rate when not stalled.
// Each output item is the per-channel rounded average (sum + 2) / 4 of a 2x2
// source block; the output frame is max(w/2,1) by max(h/2,1), an odd last
// column or row is dropped, and a source dimension of 1 pairs its single column
// or row with itself. frame_last flags the final output item of a frame.
// Source items are taken one per cycle unless the output side stalls; the edge
// that accepts an item loads stage 1 and the line RAM read data, and stage 1
// then loads the output register when that is free or being taken. The line
// RAM holds horizontal pair sums of even rows and is read back by the odd row;
// a given entry is written a full row before it is read, so no forwarding is
// needed, and entries never written in the current frame are never read.
// Register writes (index 0 width, 1 height) restart the frame and are to be
// issued only while the block is idle; the line RAM needs no clearing pass.
module rgba_box_downsample_2x (
    input  logic            clk,
    input  logic            rst_n,
    rbd2x_pix_if.sink       pix_in,
    rbd2x_out_if.source     pix_out,
    rbd2x_cfg_if.sink       cfg
);
    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [rbd2x_pkg::CFG_W-1:0]  src_width_reg;
    logic [rbd2x_pkg::CFG_W-1:0]  src_height_reg;
    logic                         cfg_fire;
    logic                         cfg_hit;

    assign cfg.ready = 1'b1;
    assign cfg_fire  = cfg.valid && cfg.ready;
    assign cfg_hit   = cfg_fire && ((cfg.index == rbd2x_pkg::REG_SRC_WIDTH) ||
                                    (cfg.index == rbd2x_pkg::REG_SRC_HEIGHT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= rbd2x_pkg::CFG_W'(1);
            src_height_reg <= rbd2x_pkg::CFG_W'(1);
        end
        else if (cfg_fire)
        begin
            if (cfg.index == rbd2x_pkg::REG_SRC_WIDTH)
            begin
                src_width_reg <= cfg.data;
            end
            if (cfg.index == rbd2x_pkg::REG_SRC_HEIGHT)
            begin
                src_height_reg <= cfg.data;
            end
        end
    end

    // Effective (clamped) frame size and derived limits
    logic [rbd2x_pkg::WDIM_W-1:0] eff_w;
    logic [rbd2x_pkg::HDIM_W-1:0] eff_h;
    logic                         w_one;
    logic                         h_one;
    logic [rbd2x_pkg::WDIM_W-1:0] w_even;
    logic [rbd2x_pkg::HDIM_W-1:0] h_even;
    logic [rbd2x_pkg::WDIM_W-1:0] dw_m1;
    logic [rbd2x_pkg::HDIM_W-1:0] dh_m1;

    assign eff_w  = rbd2x_pkg::eff_width(src_width_reg);
    assign eff_h  = rbd2x_pkg::eff_height(src_height_reg);
    assign w_one  = (eff_w == rbd2x_pkg::WDIM_W'(1));
    assign h_one  = (eff_h == rbd2x_pkg::HDIM_W'(1));
    assign w_even = {eff_w[rbd2x_pkg::WDIM_W-1:1], 1'b0};
    assign h_even = {eff_h[rbd2x_pkg::HDIM_W-1:1], 1'b0};
    assign dw_m1  = w_one ? '0 : ((eff_w >> 1) - rbd2x_pkg::WDIM_W'(1));
    assign dh_m1  = h_one ? '0 : ((eff_h >> 1) - rbd2x_pkg::HDIM_W'(1));

    // ---------------------------------------------------------------
    // Stage 0: raster position, horizontal pairing, line RAM access
    // ---------------------------------------------------------------
    logic [rbd2x_pkg::WCNT_W-1:0] col_reg;
    logic [rbd2x_pkg::HCNT_W-1:0] row_reg;
    logic [rbd2x_pkg::WCNT_W-1:0] col_next;
    logic [rbd2x_pkg::HCNT_W-1:0] row_next;
    rbd2x_pkg::pixel_t            held_reg;
    rbd2x_pkg::pixel_t            px;
    rbd2x_pkg::pair_t             pair;
    logic [rbd2x_pkg::LINE_AW-1:0] xpos;
    logic [rbd2x_pkg::HCNT_W-1:0] ypos;
    logic                         in_fire;
    logic                         col_ok;
    logic                         row_ok;
    logic                         pair_ok;
    logic                         hold_now;
    logic                         wr_now;
    logic                         rd_now;
    logic                         emit_now;
    logic                         last_now;
    logic [rbd2x_pkg::WDIM_W-1:0] col_inc;
    logic [rbd2x_pkg::HDIM_W-1:0] row_inc;

    assign px = {pix_in.in_alpha, pix_in.in_blue, pix_in.in_green, pix_in.in_red};

    always_comb
    begin
        col_ok  = ({1'b0, col_reg} < w_even);
        row_ok  = ({1'b0, row_reg} < h_even);
        pair_ok = w_one || (col_ok && col_reg[0]);
        hold_now = !w_one && col_ok && !col_reg[0];
        for (int i = 0; i < rbd2x_pkg::NCH; i++)
        begin
            if (w_one)
            begin
                pair[i] = {px[i], 1'b0};
            end
            else
            begin
                pair[i] = rbd2x_pkg::PSUM_W'(held_reg[i]) + rbd2x_pkg::PSUM_W'(px[i]);
            end
        end
        xpos     = w_one ? '0 : col_reg[rbd2x_pkg::WCNT_W-1:1];
        ypos     = h_one ? '0 : (row_reg >> 1);
        wr_now   = pair_ok && !h_one && row_ok && !row_reg[0];
        rd_now   = pair_ok && !h_one && row_ok && row_reg[0];
        emit_now = pair_ok && (h_one || rd_now);
        last_now = (rbd2x_pkg::WDIM_W'(xpos) == dw_m1) &&
                   (rbd2x_pkg::HDIM_W'(ypos) == dh_m1);

        // raster advance with wrap at end of row and frame
        col_inc  = rbd2x_pkg::WDIM_W'(col_reg) + rbd2x_pkg::WDIM_W'(1);
        row_inc  = rbd2x_pkg::HDIM_W'(row_reg) + rbd2x_pkg::HDIM_W'(1);
        col_next = col_reg;
        row_next = row_reg;
        if (col_inc >= eff_w)
        begin
            col_next = '0;
            row_next = (row_inc >= eff_h) ? '0 : row_inc[rbd2x_pkg::HCNT_W-1:0];
        end
        else
        begin
            col_next = col_inc[rbd2x_pkg::WCNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            held_reg <= '0;
        end
        else if (cfg_hit)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            held_reg <= '0;
        end
        else if (in_fire)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (hold_now)
            begin
                held_reg <= px;
            end
        end
    end

    // Line RAM: even-row pair sums, read back by the odd row
    logic                          ram_we;
    logic                          ram_re;
    logic [$bits(rbd2x_pkg::pair_t)-1:0] ram_rdata;
    rbd2x_pkg::pair_t              line_pair;

    assign ram_we    = in_fire && wr_now;
    assign ram_re    = in_fire && rd_now;
    assign line_pair = rbd2x_pkg::pair_t'(ram_rdata);

    rbd2x_ram #(
        .WIDTH ($bits(rbd2x_pkg::pair_t)),
        .DEPTH (rbd2x_pkg::LINE_DEPTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (xpos),
        .wdata (pair),
        .re    (ram_re),
        .raddr (xpos),
        .rdata (ram_rdata)
    );

    // ---------------------------------------------------------------
    // Stage 1: vertical sum and rounding (RAM data arrives here)
    // ---------------------------------------------------------------
    logic                         s1_valid_reg;
    rbd2x_pkg::pair_t             s1_pair_reg;
    logic                         s1_rd_reg;
    logic                         s1_last_reg;
    logic                         s1_move;
    rbd2x_pkg::pixel_t            avg;
    logic [rbd2x_pkg::QSUM_W-1:0] qsum;

    logic                         out_valid_reg;
    rbd2x_pkg::pixel_t            out_pix_reg;
    logic                         out_last_reg;

    // Stage 1 drains into the output register when that is free or being taken.
    // RAM read data holds while stage 1 stalls, since no new read can be issued.
    assign s1_move      = s1_valid_reg && (!out_valid_reg || pix_out.ready);
    assign pix_in.ready = !s1_valid_reg || s1_move;
    assign in_fire      = pix_in.valid && pix_in.ready;

    always_comb
    begin
        qsum = '0;
        for (int i = 0; i < rbd2x_pkg::NCH; i++)
        begin
            if (s1_rd_reg)
            begin
                qsum = rbd2x_pkg::QSUM_W'(line_pair[i]) + rbd2x_pkg::QSUM_W'(s1_pair_reg[i]);
            end
            else
            begin
                qsum = rbd2x_pkg::QSUM_W'({s1_pair_reg[i], 1'b0});
            end
            qsum   = qsum + rbd2x_pkg::QSUM_W'(2);
            avg[i] = qsum[rbd2x_pkg::CH_W+1:2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            s1_valid_reg <= emit_now;
        end
        else if (s1_move)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_pair_reg <= pair;
            s1_rd_reg   <= rd_now;
            s1_last_reg <= last_now;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_move)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (pix_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            out_pix_reg  <= avg;
            out_last_reg <= s1_last_reg;
        end
    end

    assign pix_out.valid      = out_valid_reg;
    assign pix_out.out_red    = out_pix_reg[0];
    assign pix_out.out_green  = out_pix_reg[1];
    assign pix_out.out_blue   = out_pix_reg[2];
    assign pix_out.out_alpha  = out_pix_reg[3];
    assign pix_out.frame_last = out_last_reg;

`ifndef SYNTHESIS
    // raster position always inside the configured frame
    assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, col_reg} < eff_w) && ({1'b0, row_reg} < eff_h))
        else $error("raster position outside frame");

    // the line RAM is never written and read in the same cycle
    assert property (@(posedge clk) disable iff (!rst_n) !(ram_we && ram_re))
        else $error("line RAM read and write collide");

    // an item that reads the line RAM lands in stage 1 marked as a read
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && rd_now |=> s1_valid_reg && s1_rd_reg)
        else $error("line read lost on its way to stage 1");

    // a stalled stage 1 item is kept until it moves on
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_move |=> s1_valid_reg && $stable(s1_pair_reg))
        else $error("stage 1 item dropped while stalled");
`endif
endmodule

### sv/rbd2x_ram.sv
// rbd2x_ram: generic single-port-write, single-port-read synchronous RAM.
// Read data is registered and only updates on a read enable. No dependencies.
module rbd2x_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

### test/rgba_box_downsample_2x_chk.sv
// rgba_box_downsample_2x_chk: watches the pixel, output and register channels, predicts
// every downsampled item and compares it field by field with what the block delivers.
// Depends on rbd2x_pkg, rbd2x_pix_if, rbd2x_out_if and rbd2x_cfg_if.
module rgba_box_downsample_2x_chk (
    input  logic    clk,
    input  logic    rst_n,
    rbd2x_pix_if    pix,
    rbd2x_out_if    res,
    rbd2x_cfg_if    cfg,
    input  logic    wrap_up,
    output int      mismatches,
    output int      pending,
    output int      matched
);
    timeunit 1ns;
    timeprecision 1ps;
    import rbd2x_pkg::*;

    localparam int PRINT_CAP = 20;

    typedef struct packed {
        pixel_t rgba;
        logic   last;
    } down_pix_t;

    string chan_names [NCH] = '{"red", "green", "blue", "alpha"};

    // Shadow of the block: registers, line of pair sums, raster position
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    pair_t            pair_line [LINE_DEPTH];
    pixel_t           held;
    int unsigned      col;
    int unsigned      row;

    down_pix_t        due_pixels [$];
    int               bad_count = 0;
    int               good_count = 0;
    int               due_count = 0;
    bit               wrapped = 0;

    assign mismatches = bad_count;
    assign pending    = due_count;
    assign matched    = good_count;

    function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] raw,
                                              input int unsigned cap);
        int unsigned v;
        v = raw;
        if (v == 0) begin
            v = 1;
        end else if (v > cap) begin
            v = cap;
        end
        return v;
    endfunction

    task automatic report_mismatch(input string msg);
        bad_count++;
        if (bad_count <= PRINT_CAP) begin
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        end
    endtask

    task automatic restart_frame();
        held = '0;
        col  = 0;
        row  = 0;
    endtask

    task automatic apply_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        if (idx == REG_SRC_WIDTH) begin
            width_reg = val;
            restart_frame();
        end else if (idx == REG_SRC_HEIGHT) begin
            height_reg = val;
            restart_frame();
        end
    endtask

    // One source pixel in; at most one averaged block out
    task automatic box_average_step(input pixel_t px);
        int unsigned w, h, dw, dh, x, y;
        int unsigned hsum [NCH];
        int unsigned vsum [NCH];
        int          ch;
        bit          have_pair;
        bit          emit;
        down_pix_t   item;
        w  = clamp_dim(width_reg, MAX_WIDTH);
        h  = clamp_dim(height_reg, HEIGHT_CAP);
        dw = (w / 2 == 0) ? 1 : w / 2;
        dh = (h / 2 == 0) ? 1 : h / 2;
        have_pair = 0;
        emit      = 0;
        x         = 0;
        y         = 0;

        // horizontal pair; a single column pairs with itself
        if (w == 1) begin
            for (ch = 0; ch < NCH; ch++) begin
                hsum[ch] = 2 * px[ch];
            end
            have_pair = 1;
        end else if (col < 2 * dw) begin
            if (col % 2 == 0) begin
                held = px;
            end else begin
                for (ch = 0; ch < NCH; ch++) begin
                    hsum[ch] = held[ch] + px[ch];
                end
                have_pair = 1;
                x = col / 2;
            end
        end

        // vertical pair; even rows fill the line, odd rows read it
        if (have_pair) begin
            if (h == 1) begin
                for (ch = 0; ch < NCH; ch++) begin
                    vsum[ch] = 2 * hsum[ch];
                end
                emit = 1;
            end else if (row < 2 * dh) begin
                if (row % 2 == 0) begin
                    for (ch = 0; ch < NCH; ch++) begin
                        pair_line[x][ch] = PSUM_W'(hsum[ch]);
                    end
                end else begin
                    for (ch = 0; ch < NCH; ch++) begin
                        vsum[ch] = pair_line[x][ch] + hsum[ch];
                    end
                    emit = 1;
                    y = row / 2;
                end
            end
        end

        if (emit) begin
            for (ch = 0; ch < NCH; ch++) begin
                item.rgba[ch] = CH_W'((vsum[ch] + 2) >> 2);
            end
            item.last = (x == dw - 1) && (y == dh - 1);
            due_pixels = {due_pixels, item};
        end

        col++;
        if (col >= w) begin
            col = 0;
            row++;
            if (row >= h) begin
                row = 0;
            end
        end
    endtask

    task automatic check_result();
        down_pix_t want;
        pixel_t    got;
        int        ch;
        got = {res.out_alpha, res.out_blue, res.out_green, res.out_red};
        if (due_pixels.size() == 0) begin
            report_mismatch($sformatf("output item %h/%b with none expected", got,
                                      res.frame_last));
        end else begin
            want = due_pixels.pop_front();
            for (ch = 0; ch < NCH; ch++) begin
                if (got[ch] !== want.rgba[ch]) begin
                    report_mismatch($sformatf("item %0d %s: got %0d, expected %0d",
                                              good_count, chan_names[ch], got[ch],
                                              want.rgba[ch]));
                end
            end
            if (res.frame_last !== want.last) begin
                report_mismatch($sformatf("item %0d frame_last: got %b, expected %b",
                                          good_count, res.frame_last, want.last));
            end
            good_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            width_reg  = CFG_W'(1);
            height_reg = CFG_W'(1);
            restart_frame();
            due_pixels.delete();
            due_count = 0;
        end else begin
            if (cfg.valid && cfg.ready) begin
                apply_write(cfg.index, cfg.data);
            end
            if (pix.valid && pix.ready) begin
                box_average_step({pix.in_alpha, pix.in_blue, pix.in_green, pix.in_red});
            end
            if (res.valid && res.ready) begin
                check_result();
            end
            if (wrap_up && !wrapped) begin
                wrapped = 1;
                if (due_pixels.size() != 0) begin
                    report_mismatch($sformatf("%0d expected output items never arrived",
                                              due_pixels.size()));
                end
            end
            due_count = due_pixels.size();
        end
    end

endmodule

### test/rgba_box_downsample_2x_tb.sv
// rgba_box_downsample_2x_tb: stimulus and verdict for the RGBA 2x2 box downsampler.
// Depends on rbd2x_pkg, the three channel interfaces, rgba_box_downsample_2x and
// rgba_box_downsample_2x_chk (which does all prediction and comparison).
module rgba_box_downsample_2x_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rbd2x_pkg::*;

    // Register indexes past the end of the map: writes must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);

    localparam int IDLE_PCT     = 29;    // idle cycles per hundred, each side
    localparam int HOLD_CYCLES  = 200;   // long output hold-off to back up the pipe
    localparam int STALL_LIMIT  = 2000;  // cycles with no item moving anywhere
    localparam int DRAIN_CYCLES = 8;     // drain time after the last expected item, with margin
    localparam int WIDE_ITEMS   = 300;
    localparam int TALL_ITEMS   = 200;
    localparam int RANDOM_ITEMS = 760;

    logic clk;
    logic rst_n;
    logic wrap_up;

    int   mismatches;
    int   pending;
    int   matched;

    bit   steady;        // no idling on either side while set
    bit   hold_req;      // ask the output side for one long hold-off
    int   sent_items;
    int   cfg_writes;
    int   quiet;

    rbd2x_pix_if pix_in_if ();
    rbd2x_out_if pix_out_if ();
    rbd2x_cfg_if cfg_if ();

    rgba_box_downsample_2x i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .pix_in  (pix_in_if),
        .pix_out (pix_out_if),
        .cfg     (cfg_if)
    );

    rgba_box_downsample_2x_chk i_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .pix        (pix_in_if),
        .res        (pix_out_if),
        .cfg        (cfg_if),
        .wrap_up    (wrap_up),
        .mismatches (mismatches),
        .pending    (pending),
        .matched    (matched)
    );

    initial begin
        clk = 1'b0;
        forever begin
            #2 clk = ~clk;
        end
    end

    // Output side: random back-pressure, or a long hold-off when asked.
    // The hold-off is counted here so the sender keeps pushing meanwhile.
    initial begin : out_side
        int hold_left;
        hold_left = 0;
        pix_out_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req && hold_left == 0) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                pix_out_if.ready <= 1'b0;
            end else begin
                pix_out_if.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Watchdog: any item moving on any channel restarts the count
    always @(posedge clk) begin
        if ((pix_in_if.valid && pix_in_if.ready) || (pix_out_if.valid && pix_out_if.ready) ||
            (cfg_if.valid && cfg_if.ready)) begin
            quiet = 0;
        end else begin
            quiet++;
        end
        if (quiet >= STALL_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
            $display("** rgba_box_downsample_2x: FAILED **");
            $finish;
        end
    end

    // Random idle cycles before an item; payload is junk while valid is low
    task automatic idle_gap();
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            pix_in_if.valid    <= 1'b0;
            pix_in_if.in_red   <= CH_W'($urandom);
            pix_in_if.in_green <= CH_W'($urandom);
            pix_in_if.in_blue  <= CH_W'($urandom);
            pix_in_if.in_alpha <= CH_W'($urandom);
            @(negedge clk);
        end
    endtask

    // Offer one source pixel and wait for it to be taken. Valid stays high
    // afterwards so back-to-back items go at full rate.
    task automatic send_pixel(input pixel_t px);
        idle_gap();
        pix_in_if.valid    <= 1'b1;
        pix_in_if.in_red   <= px[0];
        pix_in_if.in_green <= px[1];
        pix_in_if.in_blue  <= px[2];
        pix_in_if.in_alpha <= px[3];
        @(posedge clk);
        while (!pix_in_if.ready) begin
            @(posedge clk);
        end
        @(negedge clk);
        sent_items++;
    endtask

    task automatic send_random(input int n);
        repeat (n) begin
            send_pixel(pixel_t'($urandom));
        end
    endtask

    // Register write; valid is left high for a following write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        @(posedge clk);
        while (!cfg_if.ready) begin
            @(posedge clk);
        end
        @(negedge clk);
        cfg_writes++;
    endtask

    task automatic end_writes();
        cfg_if.valid <= 1'b0;
        @(negedge clk);
    endtask

    // Wait until every expected item is out, then let dropped pixels
    // still in the pipe clear before touching the registers.
    task automatic settle();
        pix_in_if.valid <= 1'b0;
        while (pending != 0) begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) begin
            @(negedge clk);
        end
    endtask

    // New frame geometry, both registers in random order, now and then with
    // a stray write to an unmapped index mixed in.
    task automatic set_frame(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        settle();
        if ($urandom_range(1) == 0) begin
            write_reg(REG_SRC_WIDTH, w);
            write_reg(REG_SRC_HEIGHT, h);
        end else begin
            write_reg(REG_SRC_HEIGHT, h);
            write_reg(REG_SRC_WIDTH, w);
        end
        if ($urandom_range(5) == 0) begin
            write_reg(($urandom_range(1) == 0) ? REG_SPARE_A : REG_SPARE_B, CFG_W'($urandom));
        end
        end_writes();
    endtask

    initial begin : stimulus
        int i;
        int w;
        int h;
        int n;
        int random_sent;
        int phases;

        rst_n              = 1'b0;
        wrap_up            = 1'b0;
        steady             = 0;
        hold_req           = 0;
        sent_items         = 0;
        cfg_writes         = 0;
        quiet              = 0;
        random_sent        = 0;
        phases             = 0;
        pix_in_if.valid    = 1'b0;
        pix_in_if.in_red   = '0;
        pix_in_if.in_green = '0;
        pix_in_if.in_blue  = '0;
        pix_in_if.in_alpha = '0;
        cfg_if.valid       = 1'b0;
        cfg_if.index       = REG_SRC_WIDTH;
        cfg_if.data        = '0;

        repeat (10) begin
            @(negedge clk);
        end
        rst_n <= 1'b1;
        @(negedge clk);

        // --- directed ---
        // Reset geometry is 1x1: each pixel comes back unchanged, extremes first
        send_pixel('0);
        send_pixel('1);

        // 3x3: odd last column and row dropped, one item from the top-left block
        set_frame(3, 3);
        for (i = 0; i < 9; i++) begin
            send_pixel({CH_W'(i * 85), CH_W'(i % 4), CH_W'(255 - i), CH_W'(i * 37)});
        end

        // Zero width acts as one column, paired with itself; 0/255 mix rounds up
        set_frame(0, 2);
        send_pixel('1);
        send_pixel('0);

        // Single row paired with itself
        set_frame(2, 1);
        send_random(4);

        // Unmapped writes mid-frame must not restart it
        set_frame(4, 2);
        send_random(4);
        settle();
        write_reg(REG_SPARE_A, '1);
        write_reg(REG_SPARE_B, '1);
        end_writes();
        send_random(4);

        // --- extremes ---
        // Width past the maximum saturates; a single row pairs with itself, so
        // every second pixel yields an item and the long output hold-off early
        // on fills the pipe and stalls the sender.
        set_frame('1, 1);
        hold_req = 1;
        send_random(WIDE_ITEMS);

        // Height past the cap saturates; single column, full-rate on both sides
        set_frame(0, '1);
        steady = 1;
        send_random(TALL_ITEMS);
        steady = 0;

        // --- random frames ---
        // Mostly small geometries, whole frames with random pixels; a third of
        // the phases stop partway so the next register write cuts the frame.
        while (random_sent < RANDOM_ITEMS) begin
            w = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            h = ($urandom_range(9) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 8);
            set_frame(CFG_W'(w), CFG_W'(h));
            n = $urandom_range(1, 3) * w * h;
            if (w * h > 1 && $urandom_range(2) == 0) begin
                n += $urandom_range(1, w * h - 1);
            end
            if (n > RANDOM_ITEMS - random_sent) begin
                n = RANDOM_ITEMS - random_sent;
            end
            if (phases == 6) begin
                hold_req = 1;
            end
            send_random(n);
            random_sent += n;
            phases++;
        end

        // --- wrap up ---
        settle();
        wrap_up <= 1'b1;
        @(negedge clk);

        $display("Sent %0d source pixels (%0d random over %0d frame setups), %0d register writes;",
                 sent_items, random_sent, phases, cfg_writes);
        $display("checked %0d downsampled items, incl. saturated width and height settings.",
                 matched);
        if (mismatches == 0) begin
            $display("** rgba_box_downsample_2x: PASSED **");
        end else begin
            $display("** rgba_box_downsample_2x: FAILED **");
        end
        $finish;
    end

endmodule
